// File: src/plma_pkg.sv
// Shared types, codes and defaults for the per-label moment accumulator.
package plma_pkg;

	localparam int NUM_LABELS_DEF = 1024;
	localparam int COUNT_BITS_DEF = 24;

	localparam logic [1:0] MODE_ACC = 2'd0;
	localparam logic [1:0] MODE_QRY = 2'd1;
	localparam logic [1:0] MODE_CLR = 2'd2;

	localparam logic [2:0] STAT_ACCEPTED  = 3'd0;
	localparam logic [2:0] STAT_IGNORED   = 3'd1;
	localparam logic [2:0] STAT_SATURATED = 3'd2;
	localparam logic [2:0] STAT_QUERY_OK  = 3'd3;
	localparam logic [2:0] STAT_EMPTY     = 3'd4;

	localparam logic CFG_LABEL_FLOOR = 1'b0;
	localparam logic CFG_MEAN_ONLY   = 1'b1;

	localparam logic [2:0] RES_IGN   = 3'd0;
	localparam logic [2:0] RES_ACC   = 3'd1;
	localparam logic [2:0] RES_CLR   = 3'd2;
	localparam logic [2:0] RES_EMPTY = 3'd3;
	localparam logic [2:0] RES_QRY   = 3'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] label;
		logic signed [15:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [23:0]        voxel_count;
		logic signed [15:0] mean_value;
		logic [14:0]        std_dev;
	} out_item_t;

	typedef struct packed {
		logic       clr_wr;
		logic       load;
		logic       rd;
		logic       acc_wr;
		logic       del_wr;
		logic       div_sum_start;
		logic       div_sq_start;
		logic       div_step;
		logic       mean_cap;
		logic       sqrt_start;
		logic       sqrt_step;
		logic       out_load;
		logic [2:0] res_sel;
	} plma_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       lbl_ok;
		logic       lbl_in_range;
		logic       cnt_zero;
		logic       mean_only;
		logic       div_done;
		logic       sqrt_done;
		logic       clr_done;
		logic       out_free;
	} plma_stat_t;

endpackage

// File: src/plma_ctrl.sv
// Sequencing state machine for the per-label moment accumulator.
module plma_ctrl
	import plma_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  plma_stat_t st,
	output plma_cmd_t  cmd
);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_EXEC = 4'd3;
	localparam logic [3:0] S_DIVS = 4'd4;
	localparam logic [3:0] S_MEAN = 4'd5;
	localparam logic [3:0] S_DIVQ = 4'd6;
	localparam logic [3:0] S_VAR  = 4'd7;
	localparam logic [3:0] S_SQRT = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic [3:0] state_q, state_d;
	logic [2:0] res_q, res_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res_sel = res_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_FIN;
				res_d   = RES_IGN;
				priority if (st.mode == MODE_ACC) begin
					if (st.lbl_ok) begin
						cmd.acc_wr = 1'b1;
						res_d      = RES_ACC;
					end
				end else if (st.mode == MODE_QRY) begin
					if (st.lbl_ok) begin
						if (st.cnt_zero) begin
							res_d = RES_EMPTY;
						end else begin
							cmd.div_sum_start = 1'b1;
							state_d           = S_DIVS;
						end
					end
				end else if (st.mode == MODE_CLR) begin
					if (st.lbl_in_range) begin
						cmd.del_wr = 1'b1;
						res_d      = RES_CLR;
					end
				end else begin
					res_d = RES_IGN;
				end
			end
			S_DIVS: begin
				cmd.div_step = 1'b1;
				if (st.div_done) state_d = S_MEAN;
			end
			S_MEAN: begin
				cmd.mean_cap = 1'b1;
				if (st.mean_only) begin
					res_d   = RES_QRY;
					state_d = S_FIN;
				end else begin
					cmd.div_sq_start = 1'b1;
					state_d          = S_DIVQ;
				end
			end
			S_DIVQ: begin
				cmd.div_step = 1'b1;
				if (st.div_done) state_d = S_VAR;
			end
			S_VAR: begin
				cmd.sqrt_start = 1'b1;
				state_d        = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (st.sqrt_done) begin
					res_d   = RES_QRY;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			res_q   <= RES_IGN;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free) else $error("result loaded into a full output");
	a_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall) else $error("input not stalled after a beat");
	a_exec_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> $past(state_q == S_RD)) else $error("entry used before read");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_wr || cmd.del_wr) |-> !cmd.clr_wr) else $error("table written twice");

endmodule

// File: src/plma_datapath.sv
// Label table, shared divider, square root unit and result register.
module plma_datapath
	import plma_pkg::*;
#(
	parameter int NUM_LABELS = NUM_LABELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_item,
	input  logic       cfg_valid,
	input  logic       cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       out_stall,
	output logic       out_valid,
	output out_item_t  out_item,
	input  plma_cmd_t  cmd,
	output plma_stat_t st
);

	localparam int IDX_W = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
	localparam int SUM_W = COUNT_BITS + 16;
	localparam int SQ_W  = COUNT_BITS + 30;
	localparam int ENT_W = COUNT_BITS + SUM_W + SQ_W;
	localparam int DVD_W = SQ_W;
	localparam int DC_W  = $clog2(DVD_W);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [9:0]            floor_q;
	logic                  mean_only_q;
	in_item_t              item_q;
	logic signed [31:0]    samp_w;
	logic signed [31:0]    samp_prod;
	logic [30:0]           samp_sq_q;
	logic [ENT_W-1:0]      mem [NUM_LABELS];
	logic [ENT_W-1:0]      rd_q;
	logic [IDX_W-1:0]      clr_addr_q;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [SUM_W-1:0]      rd_sum;
	logic [SQ_W-1:0]       rd_sq;
	logic [IDX_W-1:0]      idx;
	logic [16:0]           lbl_u;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [ENT_W-1:0]      wr_data;
	logic                  sat;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [SUM_W-1:0]      samp_ext;
	logic [23:0]           cnt_res_q;
	logic                  sat_q;
	logic [DVD_W-1:0]      dvd_q;
	logic [COUNT_BITS:0]   rem_q;
	logic [COUNT_BITS:0]   rem_trial;
	logic [DC_W-1:0]       dcnt_q;
	logic                  neg_q;
	logic [SUM_W-1:0]      sum_abs;
	logic signed [16:0]    mean_q;
	logic [30:0]           msq_q;
	logic signed [33:0]    msq_full;
	logic signed [31:0]    var_v;
	logic [31:0]           rad_q;
	logic [17:0]           srem_q;
	logic [15:0]           root_q;
	logic [3:0]            scnt_q;
	logic [17:0]           s_trial_rem;
	logic [17:0]           s_trial;
	out_item_t             res;
	logic [14:0]           sd;

	assign rd_cnt = rd_q[ENT_W-1 -: COUNT_BITS];
	assign rd_sum = rd_q[SQ_W +: SUM_W];
	assign rd_sq  = rd_q[SQ_W-1:0];
	assign idx    = item_q.label[IDX_W-1:0];
	assign lbl_u  = {1'b0, item_q.label};

	assign st.mode         = item_q.mode;
	assign st.lbl_in_range = !item_q.label[15] && (lbl_u < 17'(NUM_LABELS));
	assign st.lbl_ok       = st.lbl_in_range && (lbl_u > {7'd0, floor_q});
	assign st.cnt_zero     = (rd_cnt == '0);
	assign st.mean_only    = mean_only_q;
	assign st.div_done     = (dcnt_q == DC_W'(DVD_W - 1));
	assign st.sqrt_done    = (scnt_q == 4'd15);
	assign st.clr_done     = (clr_addr_q == IDX_W'(NUM_LABELS - 1));
	assign st.out_free     = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q     <= '0;
			mean_only_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_LABEL_FLOOR) floor_q <= cfg_data;
			else mean_only_q <= cfg_data[0];
		end
	end

	// The square of the most negative sample needs the full 31 bits.
	assign samp_w    = {{16{item_q.sample[15]}}, item_q.sample};
	assign samp_prod = samp_w * samp_w;

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.rd) samp_sq_q <= samp_prod[30:0];
	end

	// Table: one write port, one registered read port.
	assign sat      = (rd_cnt == CNT_MAX);
	assign new_cnt  = rd_cnt + 1'b1;
	assign samp_ext = {{(SUM_W-16){item_q.sample[15]}}, item_q.sample};
	assign wr_en    = cmd.clr_wr || cmd.del_wr || (cmd.acc_wr && !sat);
	assign wr_addr  = cmd.clr_wr ? clr_addr_q : idx;
	assign wr_data  = cmd.acc_wr ? {new_cnt, rd_sum + samp_ext, rd_sq + SQ_W'(samp_sq_q)}
	                             : '0;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd) rd_q <= mem[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_addr_q <= '0;
		else if (cmd.clr_wr && !st.clr_done) clr_addr_q <= clr_addr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_wr) begin
			cnt_res_q <= sat ? 24'(rd_cnt) : 24'(new_cnt);
			sat_q     <= sat;
		end else if (cmd.div_sum_start) begin
			cnt_res_q <= 24'(rd_cnt);
			sat_q     <= 1'b0;
		end
	end

	// Restoring divider, one quotient bit per cycle; quotient replaces dividend.
	assign sum_abs   = rd_sum[SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;
	assign rem_trial = {rem_q[COUNT_BITS-1:0], dvd_q[DVD_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_sum_start || cmd.div_sq_start) begin
			dvd_q  <= cmd.div_sum_start ? DVD_W'(sum_abs) : rd_sq;
			rem_q  <= '0;
			dcnt_q <= '0;
			if (cmd.div_sum_start) neg_q <= rd_sum[SUM_W-1];
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (rem_trial >= {1'b0, rd_cnt}) begin
				rem_q <= rem_trial - {1'b0, rd_cnt};
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_trial;
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign msq_full = mean_q * mean_q;

	always_ff @(posedge clk) begin
		if (cmd.mean_cap) mean_q <= neg_q ? -$signed(dvd_q[16:0]) : $signed(dvd_q[16:0]);
		if (cmd.div_step) msq_q <= 31'(msq_full);
	end

	// Digit-by-digit square root, two radicand bits per cycle.
	assign var_v       = $signed({1'b0, dvd_q[30:0]}) - $signed({1'b0, msq_q});
	assign s_trial_rem = {srem_q[15:0], rad_q[31:30]};
	assign s_trial     = {root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			rad_q  <= (var_v > 0) ? 32'(var_v) : '0;
			srem_q <= '0;
			root_q <= '0;
			scnt_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[29:0], 2'b00};
			scnt_q <= scnt_q + 1'b1;
			if (s_trial_rem >= s_trial) begin
				srem_q <= s_trial_rem - s_trial;
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				srem_q <= s_trial_rem;
				root_q <= {root_q[14:0], 1'b0};
			end
		end
	end

	assign sd = (mean_only_q || root_q[15]) ? (mean_only_q ? 15'd0 : 15'h7FFF) : root_q[14:0];

	always_comb begin
		res        = '0;
		res.status = STAT_IGNORED;
		unique case (cmd.res_sel)
			RES_ACC: begin
				res.status      = sat_q ? STAT_SATURATED : STAT_ACCEPTED;
				res.voxel_count = cnt_res_q;
			end
			RES_CLR:   res.status = STAT_ACCEPTED;
			RES_EMPTY: res.status = STAT_EMPTY;
			RES_QRY: begin
				res.status      = STAT_QUERY_OK;
				res.voxel_count = cnt_res_q;
				res.mean_value  = mean_q[15:0];
				res.std_dev     = sd;
			end
			default: res.status = STAT_IGNORED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_item <= res;
	end

endmodule

// File: src/per_label_moment_accumulator.sv
// Accumulate, clear and ignored items pass the read, execute and finish states to the result.
// A query also runs the bit-serial divider twice (mean, then mean square) and a 16-step
// square root; mean-only queries skip the mean-square division and the square root.
// Throughput: one item at a time; the next input beat is taken once the result is loaded.
// Reset: asynchronous, active low; afterwards a clearing pass over every entry zeroes
// the table, during which input stays stalled (configuration writes are still taken).
module per_label_moment_accumulator
	import plma_pkg::*;
#(
	parameter int NUM_LABELS = NUM_LABELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [9:0] cfg_data
);

	plma_cmd_t  cmd;
	plma_stat_t st;

	// The configuration registers take a beat in every cycle.
	assign cfg_ready = 1'b1;

	// The controller only sequences; all state of the table and arithmetic lives in
	// the datapath, which reports back through the status struct.
	plma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	plma_datapath #(
		.NUM_LABELS (NUM_LABELS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
